/* rtl/xss_pkg.sv */
// shared types and constants for the xoshiro256** generator with splitmix64 seeding
// no dependencies
package xss_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned FracW = 53;
  localparam int unsigned Lanes = 4;
  localparam int unsigned LaneW = 2;

  localparam logic [WordW-1:0] GoldenStep = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMulA    = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMulB    = 64'h94d049bb133111eb;

  localparam int unsigned LaneShift = 17;
  localparam int unsigned LaneRot   = 45;
  localparam int unsigned FracDrop  = WordW - FracW;

  localparam logic CmdSeed = 1'b0;
  localparam logic CmdDraw = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_ADD,
    ST_MUL_LL,
    ST_MUL_LH,
    ST_MUL_HL,
    ST_MIX_XOR,
    ST_STORE
  } xss_state_t;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL
  } mul_phase_t;

  typedef struct packed {
    logic             seed_load;
    logic             seed_add;
    logic             mul_en;
    mul_phase_t       mul_phase;
    logic             mul_sel_b;
    logic             mix_xor;
    logic             lane_store;
    logic [LaneW-1:0] lane;
    logic             draw;
  } xss_cmd_t;

endpackage

/* rtl/xoshiro256ss_prng_with_seeding_top.sv */
// draw: one beat per cycle when out_ready does not stall; the result is registered, valid the cycle after accept
// seed: busy over 9 steps per lane for all 4 lanes (multiplier shared as 32x32 partial products)
// with no result beat; input ready is low while seeding
// reset: synchronous active-low rst_n clears the four state words and the output valid
// top level, instantiates xss_ctrl and xss_datapath; depends on xss_pkg
module xoshiro256ss_prng_with_seeding_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [xss_pkg::WordW-1:0] in_seed_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [xss_pkg::WordW-1:0] out_random_word,
  output logic [xss_pkg::FracW-1:0] out_uniform_bits
);
  import xss_pkg::*;

  xss_cmd_t cmd;

  xss_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd)
  );

  xss_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .seed_value   (in_seed_value),
    .random_word  (out_random_word),
    .uniform_bits (out_uniform_bits)
  );

endmodule

/* rtl/xss_datapath.sv */
// datapath: generator words, splitmix64 accumulator with a shared 32x32 multiplier,
// draw scrambler and result register; depends on xss_pkg
module xss_datapath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  xss_pkg::xss_cmd_t        cmd,
  input  logic [xss_pkg::WordW-1:0] seed_value,
  output logic [xss_pkg::WordW-1:0] random_word,
  output logic [xss_pkg::FracW-1:0] uniform_bits
);
  import xss_pkg::*;

  logic [WordW-1:0] words_r [Lanes];
  logic [WordW-1:0] words_nxt [Lanes];
  logic [WordW-1:0] acc_r, acc_nxt;
  logic [WordW-1:0] mix_r, mix_nxt;
  logic [WordW-1:0] prod_r, prod_nxt;
  logic [WordW-1:0] out_r, out_nxt;

  logic [WordW-1:0] acc_add;
  logic [WordW-1:0] mul_k;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [WordW-1:0] times5, rot7, scrambled, shifted, t2, t3;

  assign acc_add = acc_r + GoldenStep;
  assign mul_k   = cmd.mul_sel_b ? MixMulB : MixMulA;

  // one 32x32 partial product per cycle, cross terms only need their low half
  always_comb begin
    mul_a = mix_r[31:0];
    mul_b = mul_k[31:0];
    unique case (cmd.mul_phase)
      MUL_LL: begin
        mul_a = mix_r[31:0];
        mul_b = mul_k[31:0];
      end
      MUL_LH: begin
        mul_a = mix_r[31:0];
        mul_b = mul_k[63:32];
      end
      MUL_HL: begin
        mul_a = mix_r[63:32];
        mul_b = mul_k[31:0];
      end
      default: begin
        mul_a = mix_r[31:0];
        mul_b = mul_k[31:0];
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // scrambler: rotl(s1*5, 7)*9 with shifts and adds
  assign times5    = words_r[1] + {words_r[1][WordW-3:0], 2'b00};
  assign rot7      = {times5[WordW-8:0], times5[WordW-1:WordW-7]};
  assign scrambled = rot7 + {rot7[WordW-4:0], 3'b000};
  assign shifted   = words_r[1] << LaneShift;
  assign t2        = words_r[2] ^ words_r[0];
  assign t3        = words_r[3] ^ words_r[1];

  always_comb begin
    acc_nxt  = acc_r;
    mix_nxt  = mix_r;
    prod_nxt = prod_r;
    out_nxt  = out_r;
    for (int i = 0; i < Lanes; i++) begin
      words_nxt[i] = words_r[i];
    end

    if (cmd.seed_load) begin
      acc_nxt = seed_value;
    end
    if (cmd.seed_add) begin
      acc_nxt = acc_add;
      mix_nxt = acc_add ^ (acc_add >> 30);
    end
    if (cmd.mul_en) begin
      if (cmd.mul_phase == MUL_LL) begin
        prod_nxt = mul_p;
      end else begin
        prod_nxt = prod_r + {mul_p[31:0], 32'h0};
      end
    end
    if (cmd.mix_xor) begin
      mix_nxt = prod_r ^ (prod_r >> 27);
    end
    if (cmd.lane_store) begin
      words_nxt[cmd.lane] = prod_r ^ (prod_r >> 31);
    end
    if (cmd.draw) begin
      out_nxt      = scrambled;
      words_nxt[0] = words_r[0] ^ t3;
      words_nxt[1] = words_r[1] ^ t2;
      words_nxt[2] = t2 ^ shifted;
      words_nxt[3] = {t3[WordW-LaneRot-1:0], t3[WordW-1:WordW-LaneRot]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Lanes; i++) begin
        words_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < Lanes; i++) begin
        words_r[i] <= words_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    mix_r  <= mix_nxt;
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
  end

  assign random_word  = out_r;
  assign uniform_bits = out_r[WordW-1:FracDrop];

endmodule

/* rtl/xss_ctrl.sv */
// controller: handshake, seed sequencer over lanes and multiply phases, result valid
// depends on xss_pkg
module xss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output xss_pkg::xss_cmd_t cmd
);
  import xss_pkg::*;

  xss_state_t       state_r, state_nxt;
  logic [LaneW-1:0] lane_r, lane_nxt;
  logic             round_r, round_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    round_nxt     = round_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.mul_phase = MUL_LL;
    cmd.mul_sel_b = round_r;
    cmd.lane      = lane_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CmdDraw) begin
            cmd.draw      = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.seed_load = 1'b1;
            lane_nxt      = '0;
            round_nxt     = 1'b0;
            state_nxt     = ST_SEED_ADD;
          end
        end
      end
      ST_SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_nxt    = ST_MUL_LL;
      end
      ST_MUL_LL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_LL;
        state_nxt     = ST_MUL_LH;
      end
      ST_MUL_LH: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_LH;
        state_nxt     = ST_MUL_HL;
      end
      ST_MUL_HL: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_phase = MUL_HL;
        state_nxt     = round_r ? ST_STORE : ST_MIX_XOR;
      end
      ST_MIX_XOR: begin
        cmd.mix_xor = 1'b1;
        round_nxt   = 1'b1;
        state_nxt   = ST_MUL_LL;
      end
      ST_STORE: begin
        cmd.lane_store = 1'b1;
        round_nxt      = 1'b0;
        lane_nxt       = lane_r + LaneW'(1);
        // last lane written ends the seed
        state_nxt      = (&lane_r) ? ST_IDLE : ST_SEED_ADD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_r      <= '0;
      round_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* test/tb_xoshiro256ss_prng_with_seeding_top.sv */
// testbench for the xoshiro256** generator with splitmix64 seeding: seed and draw beats
// are predicted in-bench and each output beat is compared field by field, in order
// depends on xss_pkg and xoshiro256ss_prng_with_seeding_top
module tb_xoshiro256ss_prng_with_seeding_top;
  timeunit 1ns;
  timeprecision 1ps;

  import xss_pkg::*;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic [FracW-1:0] frac;
  } draw_result_t;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_command = CmdDraw;
  logic [WordW-1:0] in_seed_value = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [WordW-1:0] out_random_word;
  logic [FracW-1:0] out_uniform_bits;

  // state words come out of reset as zero
  logic [WordW-1:0] gen_words [Lanes] = '{default: '0};
  draw_result_t     pending_draws [$];
  int unsigned      mismatch_count = 0;
  bit               no_idle = 1'b0;

  xoshiro256ss_prng_with_seeding_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_seed_value    (in_seed_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_word  (out_random_word),
    .out_uniform_bits (out_uniform_bits)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] v, input int amt);
    return (v << amt) | (v >> (WordW - amt));
  endfunction

  // splitmix64 expansion of the seed into the four state words
  function automatic void seed_generator(input logic [WordW-1:0] seed);
    logic [WordW-1:0] acc;
    logic [WordW-1:0] mix;
    acc = seed;
    for (int lane = 0; lane < Lanes; lane++) begin
      acc = acc + GoldenStep;
      mix = acc;
      mix = (mix ^ (mix >> 30)) * MixMulA;
      mix = (mix ^ (mix >> 27)) * MixMulB;
      gen_words[lane] = mix ^ (mix >> 31);
    end
  endfunction

  function automatic draw_result_t draw_generator();
    draw_result_t res;
    logic [WordW-1:0] shifted;
    res.word = rotl64(gen_words[1] * 5, 7) * 9;
    res.frac = res.word[WordW-1:FracDrop];
    shifted = gen_words[1] << LaneShift;
    gen_words[2] = gen_words[2] ^ gen_words[0];
    gen_words[3] = gen_words[3] ^ gen_words[1];
    gen_words[1] = gen_words[1] ^ gen_words[2];
    gen_words[0] = gen_words[0] ^ gen_words[3];
    gen_words[2] = gen_words[2] ^ shifted;
    gen_words[3] = rotl64(gen_words[3], LaneRot);
    return res;
  endfunction

  // output side back-pressure
  initial begin
    forever begin
      @(posedge clk);
      out_ready <= no_idle || ($urandom_range(99) >= 8);
    end
  end

  // compare every output beat against the oldest predicted draw
  initial begin
    draw_result_t exp_res;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_draws.size() == 0) begin
          $error("unexpected beat: random_word %h uniform_bits %h",
                 out_random_word, out_uniform_bits);
          mismatch_count++;
        end else begin
          exp_res = pending_draws.pop_front();
          if (out_random_word !== exp_res.word) begin
            $error("random_word: expected %h, got %h", exp_res.word, out_random_word);
            mismatch_count++;
          end
          if (out_uniform_bits !== exp_res.frac) begin
            $error("uniform_bits: expected %h, got %h", exp_res.frac, out_uniform_bits);
            mismatch_count++;
          end
        end
      end
    end
  end

  // called at a rising edge; returns at the edge where the beat is accepted
  task automatic send_beat(input logic cmd, input logic [WordW-1:0] seed);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 8) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_seed_value <= seed;
    do @(posedge clk); while (!in_ready);
    if (cmd == CmdSeed) seed_generator(seed);
    else pending_draws.push_back(draw_generator());
  endtask

  function automatic logic [WordW-1:0] random_seed();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return {{(WordW-1){1'b0}}, 1'b1} << $urandom_range(WordW-1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // state is zero after reset, so draws give zero and leave it zero
  task automatic test_unseeded_draws();
    repeat (3) send_beat(CmdDraw, '1);
  endtask

  task automatic test_directed_seeds();
    send_beat(CmdSeed, '0);
    repeat (2) send_beat(CmdDraw, '0);
    send_beat(CmdSeed, '1);
    repeat (2) send_beat(CmdDraw, 64'h5555_5555_5555_5555);
    send_beat(CmdSeed, 64'h0000_0000_0000_0001);
    send_beat(CmdDraw, '0);
    send_beat(CmdSeed, 64'h8000_0000_0000_0000);
    send_beat(CmdDraw, '0);
    // seed on top of a seed; the last seed below repeats an earlier seed value
    send_beat(CmdSeed, 64'haaaa_aaaa_aaaa_aaaa);
    send_beat(CmdSeed, 64'h5555_5555_5555_5555);
    repeat (3) send_beat(CmdDraw, '1);
    send_beat(CmdSeed, '0);
    repeat (3) send_beat(CmdDraw, '0);
  endtask

  task automatic test_random_traffic(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) send_beat(CmdSeed, random_seed());
      else send_beat(CmdDraw, {$urandom, $urandom});
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_traffic(300);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unseeded_draws();
    test_directed_seeds();
    test_random_traffic(700);
    test_back_to_back();
    test_random_traffic(700);
    in_valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    // a trailing seed may still be running
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/xss_pkg.sv
rtl/xss_datapath.sv
rtl/xss_ctrl.sv
rtl/xoshiro256ss_prng_with_seeding_top.sv
test/tb_xoshiro256ss_prng_with_seeding_top.sv
